### design/lvps_pkg.sv
`timescale 1ns / 1ps

package lvps_pkg;

  localparam int VALVES = 4;
  localparam int TICK_W = 16;
  localparam int CHAN_W = 3;
  localparam int MASK_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [TICK_W-1:0] BOOST_SETTLE_RESET = 16'd50;
  localparam logic [TICK_W-1:0] MUX_SETTLE_RESET = 16'd10;
  localparam logic [TICK_W-1:0] PULSE_RESET = 16'd1500;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  localparam logic [CHAN_W-1:0] OPEN_CHAN [4] = '{3'd0, 3'd2, 3'd4, 3'd7};
  localparam logic [CHAN_W-1:0] CLOSE_CHAN [4] = '{3'd3, 3'd1, 3'd6, 3'd5};

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BOOST = 2'd1,
    PH_MUX   = 2'd2,
    PH_PULSE = 2'd3
  } phase_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_SETTLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUX_SETTLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [1:0] valve_index;
    logic       open_request;
  } in_item_t;

  typedef struct packed {
    logic              boost_enable;
    logic [CHAN_W-1:0] mux_channel;
    logic              mux_common;
    logic              led_green;
    logic              led_red;
    logic              busy_res;
    logic [MASK_W-1:0] valve_open_mask;
    logic              command_rejected;
    logic              sequence_done;
  } out_item_t;

  function automatic logic [CHAN_W-1:0] valve_channel(input logic [1:0] valve,
                                                      input logic open_dir);
    logic [CHAN_W-1:0] chan;
    if (open_dir) begin
      chan = OPEN_CHAN[valve];
    end else begin
      chan = CLOSE_CHAN[valve];
    end
    return chan;
  endfunction

endpackage

### design/latching_valve_pulse_sequencer.sv
`timescale 1ns / 1ps

// Channel  Ports                                 Transaction
// in       in_valid / in_ready / in_data         tick or valve command
// out      out_valid / out_ready / out_data      one result per input transaction
// cfg      cfg_we / cfg_index / cfg_data         register write, no wait
//
// Each input transaction updates the sequencer state in the cycle it is accepted,
// and its result is registered in the output register, or in the skid register if that one is stalled.
// A two-entry output buffer (result register plus skid register) lets one new
// transaction be taken per clock; in_ready drops only while the skid register is full.
// Reset is synchronous and active low; it restores the register defaults and idles.

module latching_valve_pulse_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lvps_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lvps_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [lvps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lvps_pkg::TICK_W-1:0]         cfg_data
);

  logic [lvps_pkg::TICK_W-1:0] boost_settle_r;
  logic [lvps_pkg::TICK_W-1:0] mux_settle_r;
  logic [lvps_pkg::TICK_W-1:0] pulse_len_r;

  lvps_pkg::phase_t             phase_r, phase_nxt;
  logic [lvps_pkg::TICK_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]                  valve_r, valve_nxt;
  logic                        dir_r, dir_nxt;
  logic [lvps_pkg::MASK_W-1:0] open_bits_r, open_bits_nxt;

  lvps_pkg::out_item_t          out_r, skid_r, result;
  logic                         out_valid_r, skid_valid_r;

  logic                        accept;
  logic                        pop;
  logic                        advance;
  logic                        rejected;
  logic                        done;
  logic [lvps_pkg::TICK_W-1:0] pulse_eff;

  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pulse_eff = (pulse_len_r == '0) ? lvps_pkg::TICK_W'(1) : pulse_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boost_settle_r <= lvps_pkg::BOOST_SETTLE_RESET;
      mux_settle_r   <= lvps_pkg::MUX_SETTLE_RESET;
      pulse_len_r    <= lvps_pkg::PULSE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lvps_pkg::CFG_BOOST_SETTLE: boost_settle_r <= cfg_data;
        lvps_pkg::CFG_MUX_SETTLE:   mux_settle_r   <= cfg_data;
        lvps_pkg::CFG_PULSE:        pulse_len_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    valve_nxt     = valve_r;
    dir_nxt       = dir_r;
    open_bits_nxt = open_bits_r;
    advance       = 1'b0;
    rejected      = 1'b0;
    done          = 1'b0;

    if (in_data.mode == lvps_pkg::MODE_COMMAND) begin
      if (phase_r != lvps_pkg::PH_IDLE) begin
        rejected = 1'b1;
      end else if (int'(in_data.valve_index) < lvps_pkg::VALVES) begin
        valve_nxt = in_data.valve_index;
        dir_nxt   = in_data.open_request;
        phase_nxt = lvps_pkg::PH_BOOST;
        cnt_nxt   = '0;
        advance   = 1'b1;
      end
    end else if (phase_r != lvps_pkg::PH_IDLE) begin
      if (cnt_r != lvps_pkg::TICK_MAX) begin
        cnt_nxt = cnt_r + lvps_pkg::TICK_W'(1);
      end
      advance = 1'b1;
    end

    if (advance) begin
      if (phase_nxt == lvps_pkg::PH_BOOST && cnt_nxt >= boost_settle_r) begin
        phase_nxt = lvps_pkg::PH_MUX;
        cnt_nxt   = '0;
      end
      if (phase_nxt == lvps_pkg::PH_MUX && cnt_nxt >= mux_settle_r) begin
        phase_nxt = lvps_pkg::PH_PULSE;
        cnt_nxt   = '0;
      end
      if (phase_nxt == lvps_pkg::PH_PULSE && cnt_nxt >= pulse_eff) begin
        open_bits_nxt[valve_nxt] = dir_nxt;
        phase_nxt = lvps_pkg::PH_IDLE;
        cnt_nxt   = '0;
        done      = 1'b1;
      end
    end

    result.busy_res         = (phase_nxt != lvps_pkg::PH_IDLE);
    result.boost_enable     = result.busy_res;
    result.mux_common       = (phase_nxt == lvps_pkg::PH_PULSE);
    result.mux_channel      = '0;
    if (phase_nxt == lvps_pkg::PH_MUX || phase_nxt == lvps_pkg::PH_PULSE) begin
      result.mux_channel = lvps_pkg::valve_channel(valve_nxt, dir_nxt);
    end
    result.led_green        = result.busy_res && dir_nxt;
    result.led_red          = result.busy_res && !dir_nxt;
    result.valve_open_mask  = open_bits_nxt;
    result.command_rejected = rejected;
    result.sequence_done    = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lvps_pkg::PH_IDLE;
      cnt_r       <= '0;
      valve_r     <= '0;
      dir_r       <= 1'b0;
      open_bits_r <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      valve_r     <= valve_nxt;
      dir_r       <= dir_nxt;
      open_bits_r <= open_bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_r <= result;
      end else begin
        skid_r <= result;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  a_idle_counter_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lvps_pkg::PH_IDLE) |-> (cnt_r == '0))
    else $error("phase counter nonzero while idle");

  a_pulse_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.mux_common) |-> (out_r.busy_res && out_r.boost_enable))
    else $error("drive pulse reported without boost and busy");

  a_reject_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.command_rejected && out_r.sequence_done))
    else $error("a result is both rejected and done");

endmodule
